// ----- rtl/core/lrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the LSD radix sorter.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int KEY_W = 32;

  // One queued word from the front part to the sort engine.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             drop;
  } lrs_entry_t;

  typedef struct packed {
    logic loading;
    logic emitting;
  } lrs_status_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_DG,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SCT_RD,
    ST_SCT_DG,
    ST_SCT_WR,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } lrs_state_t;

endpackage

// ----- rtl/core/lrs_queue.sv -----
// ----------------------------------------------------------------------------
// lrs_queue
// Two-entry queue between the front part and the sort engine.
// ----------------------------------------------------------------------------
module lrs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lrs_pkg::lrs_entry_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               valid,
  output lrs_pkg::lrs_entry_t head
);
  import lrs_pkg::*;

  lrs_entry_t  slot_r [2];
  logic        rd_ptr_r, wr_ptr_r;
  logic [1:0]  fill_r;

  assign full  = (fill_r == 2'd2);
  assign valid = (fill_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/lrs_front.sv -----
// ----------------------------------------------------------------------------
// lrs_front
// Accepts key words, marks those beyond capacity as dropped, queues them.
// ----------------------------------------------------------------------------
module lrs_front #(
  parameter int MAX_ITEMS = 64,
  parameter int CNTW      = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               in_tlast,
  input  logic               q_full,
  output logic               push,
  output lrs_pkg::lrs_entry_t push_data,
  output logic [CNTW-1:0]    fill_cnt
);
  import lrs_pkg::*;

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            drop;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign drop      = (cnt_r == CNTW'(MAX_ITEMS));
  assign fill_cnt  = cnt_r;

  always_comb begin
    push_data.key  = in_tdata;
    push_data.last = in_tlast;
    push_data.drop = drop;
    cnt_nxt        = cnt_r;
    if (push) begin
      if (in_tlast)   cnt_nxt = '0;
      else if (!drop) cnt_nxt = cnt_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/lrs_back.sv -----
// ----------------------------------------------------------------------------
// lrs_back
// Sort engine: stores keys, runs the digit passes over two ping-pong
// buffers and a count table, then emits the keys in order.
// ----------------------------------------------------------------------------
module lrs_back #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 8,
  parameter int KEY_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lrs_pkg::lrs_entry_t q_head,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tlast,
  output lrs_pkg::lrs_status_t status
);
  import lrs_pkg::*;

  localparam int IW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNTW   = $clog2(MAX_ITEMS + 1);
  localparam int BINS   = (1 << DIGIT_BITS) + 1;
  localparam int BW     = DIGIT_BITS + 1;
  localparam int PASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW     = $clog2(PASSES) + 1;
  localparam int XW     = KEY_BITS + DIGIT_BITS;
  localparam int SHW    = $clog2(XW) + 1;

  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [31:0] k,
                                                     input logic [PW-1:0] p);
    logic [63:0]    ext;
    logic [XW-1:0]  xk;
    logic [SHW-1:0] sh;
    ext = {{32{k[31]}}, k};
    xk  = {{DIGIT_BITS{1'b0}}, ext[KEY_BITS-1:0]};
    // Flipping the sign bit makes unsigned digit order match signed order.
    xk[KEY_BITS-1] = ~xk[KEY_BITS-1];
    sh  = SHW'(p) * SHW'(DIGIT_BITS);
    xk  = xk >> sh;
    return xk[DIGIT_BITS-1:0];
  endfunction

  logic [31:0]     buf0 [MAX_ITEMS];
  logic [31:0]     buf1 [MAX_ITEMS];
  logic [CNTW-1:0] cnt_mem [BINS];

  lrs_state_t      state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CNTW-1:0] n_r, n_nxt;
  logic [BW-1:0]   bin_r, bin_nxt;
  logic [PW-1:0]   pass_r, pass_nxt;
  logic [CNTW-1:0] acc_r, acc_nxt;
  logic [BW-1:0]   dig_r, dig_nxt;
  logic [31:0]     key_r, key_nxt;
  logic            ov_r, ov_nxt;
  logic [31:0]     od_r, od_nxt;
  logic            ol_r, ol_nxt;

  logic [31:0]     rd0, rd1, src_rd;
  logic [CNTW-1:0] cnt_rd;
  logic            rd_sel;
  logic            b0_we, b1_we;
  logic [IW-1:0]   b0_wa, b1_wa;
  logic [31:0]     b0_wd, b1_wd;
  logic            c_we;
  logic [BW-1:0]   c_wa, c_ra;
  logic [CNTW-1:0] c_wd, sum;
  logic            idx_end;
  logic [DIGIT_BITS-1:0] dig;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  assign rd_sel  = (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) ? ~pass_r[0] : pass_r[0];
  assign src_rd  = rd_sel ? rd1 : rd0;
  assign idx_end = (CNTW'(idx_r) + CNTW'(1) == n_r);
  assign dig     = digit_of(src_rd, pass_r);
  assign sum     = acc_r + cnt_rd;

  assign status.loading  = (state_r == ST_LOAD);
  assign status.emitting = (state_r == ST_EMIT_LD);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    bin_nxt   = bin_r;
    pass_nxt  = pass_r;
    acc_nxt   = acc_r;
    dig_nxt   = dig_r;
    key_nxt   = key_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    b0_we     = 1'b0;
    b0_wa     = n_r[IW-1:0];
    b0_wd     = q_head.key;
    b1_we     = 1'b0;
    b1_wa     = idx_r;
    b1_wd     = key_r;
    c_we      = 1'b0;
    c_wa      = bin_r;
    c_wd      = '0;
    c_ra      = bin_r;
    case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_head.drop) begin
            b0_we = 1'b1;
            n_nxt = n_r + CNTW'(1);
          end
          if (q_head.last) begin
            state_nxt = ST_CLR;
            pass_nxt  = '0;
            bin_nxt   = '0;
          end
        end
      end
      ST_CLR: begin
        c_we    = 1'b1;
        bin_nxt = bin_r + BW'(1);
        if (bin_r == BW'(BINS - 1)) begin
          state_nxt = ST_CNT_RD;
          idx_nxt   = '0;
        end
      end
      ST_CNT_RD: state_nxt = ST_CNT_DG;
      ST_CNT_DG: begin
        dig_nxt   = BW'(dig) + BW'(1);
        c_ra      = BW'(dig) + BW'(1);
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        c_we    = 1'b1;
        c_wa    = dig_r;
        c_wd    = cnt_rd + CNTW'(1);
        idx_nxt = idx_r + IW'(1);
        if (idx_end) begin
          state_nxt = ST_PFX_RD;
          bin_nxt   = BW'(1);
          acc_nxt   = '0;
        end else begin
          state_nxt = ST_CNT_RD;
        end
      end
      ST_PFX_RD: state_nxt = ST_PFX_WR;
      ST_PFX_WR: begin
        c_we    = 1'b1;
        c_wd    = sum;
        acc_nxt = sum;
        bin_nxt = bin_r + BW'(1);
        if (bin_r == BW'(BINS - 1)) begin
          state_nxt = ST_SCT_RD;
          idx_nxt   = '0;
        end else begin
          state_nxt = ST_PFX_RD;
        end
      end
      ST_SCT_RD: state_nxt = ST_SCT_DG;
      ST_SCT_DG: begin
        dig_nxt   = BW'(dig);
        c_ra      = BW'(dig);
        key_nxt   = src_rd;
        state_nxt = ST_SCT_WR;
      end
      ST_SCT_WR: begin
        // The bin's running offset is the key's place in the other buffer.
        if (pass_r[0]) begin
          b0_we = 1'b1;
          b0_wa = cnt_rd[IW-1:0];
          b0_wd = key_r;
        end else begin
          b1_we = 1'b1;
          b1_wa = cnt_rd[IW-1:0];
        end
        c_we    = 1'b1;
        c_wa    = dig_r;
        c_wd    = cnt_rd + CNTW'(1);
        idx_nxt = idx_r + IW'(1);
        state_nxt = idx_end ? ST_NEXT : ST_SCT_RD;
      end
      ST_NEXT: begin
        idx_nxt = '0;
        if (pass_r == PW'(PASSES - 1)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          pass_nxt  = pass_r + PW'(1);
          bin_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (!ov_r || out_tready) begin
          ov_nxt  = 1'b1;
          od_nxt  = src_rd;
          ol_nxt  = idx_end;
          idx_nxt = idx_r + IW'(1);
          if (idx_end) begin
            state_nxt = ST_LOAD;
            n_nxt     = '0;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b0_we) buf0[b0_wa] <= b0_wd;
    if (b1_we) buf1[b1_wa] <= b1_wd;
    rd0 <= buf0[idx_r];
    rd1 <= buf1[idx_r];
  end

  always_ff @(posedge clk) begin
    if (c_we) cnt_mem[c_wa] <= c_wd;
    cnt_rd <= cnt_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
      n_r     <= '0;
      bin_r   <= '0;
      pass_r  <= '0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
      bin_r   <= bin_nxt;
      pass_r  <= pass_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    key_r <= key_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

// ----- rtl/core/lsd_radix_sort.sv -----
// ----------------------------------------------------------------------------
// lsd_radix_sort
// Stable LSD radix sorter for signed keys with a front queue and sort engine.
// ----------------------------------------------------------------------------
//  Channel | Ports                              | Word
//  input   | in_tvalid in_tready in_tdata in_tlast   | key, last of set
//  output  | out_tvalid out_tready out_tdata out_tlast | sorted key, last
//
// Loading takes a key whenever the queue holds one. After the last key, each
// digit pass clears all 2^DIGIT_BITS + 1 count entries, counts and then
// scatters each key through read, digit and write states, and forms the prefix
// sum with a read and a write state per bin; emission reads and loads each key.
// Reset is synchronous and active low. Input stalls only when the two-word
// queue is full; the output register holds its word until taken.
module lsd_radix_sort #(
  parameter int MAX_ITEMS  = 64,
  parameter int DIGIT_BITS = 8,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // sorted_key
  output logic        out_tlast
);
  import lrs_pkg::*;

  localparam int CNTW = $clog2(MAX_ITEMS + 1);

  logic            q_full, q_valid, q_pop, push;
  lrs_entry_t      push_data, q_head;
  logic [CNTW-1:0] fill_cnt;
  lrs_status_t     status;

  lrs_front #(.MAX_ITEMS(MAX_ITEMS), .CNTW(CNTW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .q_full(q_full), .push(push), .push_data(push_data), .fill_cnt(fill_cnt)
  );

  lrs_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .pop(q_pop),
    .full(q_full), .valid(q_valid), .head(q_head)
  );

  lrs_back #(.MAX_ITEMS(MAX_ITEMS), .DIGIT_BITS(DIGIT_BITS), .KEY_BITS(KEY_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .status(status)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt <= CNTW'(MAX_ITEMS))
    else $error("front key count exceeds capacity");

  a_pop_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (status.loading && q_valid))
    else $error("queue popped outside loading");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(status.emitting))
    else $error("output word raised outside emission");

endmodule
